>>> design/bsl_pkg.sv
// Package for the last-below binary search block: sizes, codes, FSM states
// and the structs passed between the controller, the store and the top level.
// No dependencies.
package bsl_pkg;

  localparam int DEPTH  = 1024;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int POS_W  = 10;
  localparam int VAL_W  = 32;
  localparam int RES_W  = 11;
  localparam int RLO_W  = 10;
  localparam int SRCH_W = IDX_W + 2;
  localparam int CFG_W  = 11;
  localparam int CIDX_W = 1;

  localparam logic [CIDX_W-1:0] CFG_RANGE_LOW  = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_RANGE_HIGH = 1'd1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } bsl_state_t;

  typedef struct packed {
    logic             wen;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             ren;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic             valid;
    logic [RES_W-1:0] index;
  } result_t;

endpackage

>>> design/bsl_ram.sv
// Element store: DEPTH x 32-bit synchronous RAM, one write and one read port,
// read data registered. Depends on bsl_pkg.
module bsl_ram
  import bsl_pkg::*;
(
  input  logic             clk,
  input  ram_req_t         req,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wen) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ren) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

>>> design/bsl_ctrl.sv
// Search controller: takes write and query requests, drives the store and
// walks the binary search one probe per read/compare pair. Depends on bsl_pkg.
module bsl_ctrl
  import bsl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_mode,
  input  logic [POS_W-1:0]        in_pos,
  input  logic [VAL_W-1:0]        in_val,
  input  logic [RLO_W-1:0]        range_low,
  input  logic signed [RES_W-1:0] range_high,
  input  logic                    res_ready,
  output result_t                 res,
  output ram_req_t                ram_req,
  input  logic [VAL_W-1:0]        rd_data
);

  localparam logic signed [SRCH_W-1:0] HIGH_MAX = SRCH_W'(DEPTH - 1);

  bsl_state_t state_r, state_nxt;
  logic signed [SRCH_W-1:0] low_r, low_nxt;
  logic signed [SRCH_W-1:0] high_r, high_nxt;
  logic signed [SRCH_W-1:0] mid_r, mid_nxt;
  logic [VAL_W-1:0]         key_r, key_nxt;

  logic signed [SRCH_W:0]   sum;
  logic signed [SRCH_W-1:0] high_init;
  logic                     accept;
  logic                     elem_below;
  logic signed [SRCH_W-1:0] low_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r  <= low_nxt;
    high_r <= high_nxt;
    mid_r  <= mid_nxt;
    key_r  <= key_nxt;
  end

  always_comb begin
    high_init = {{(SRCH_W - RES_W){range_high[RES_W-1]}}, range_high};
    if (high_init > HIGH_MAX) begin
      high_init = HIGH_MAX;
    end
    sum        = (SRCH_W + 1)'(low_r) + (SRCH_W + 1)'(high_r);
    elem_below = $signed(rd_data) < $signed(key_r);
    low_m1     = low_r - SRCH_W'(1);
    accept     = in_valid && in_ready;
  end

  always_comb begin
    state_nxt = state_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    in_ready  = 1'b0;
    res.valid = 1'b0;
    res.index = low_m1[RES_W-1:0];

    ram_req.wen   = 1'b0;
    ram_req.waddr = IDX_W'(in_pos);
    ram_req.wdata = in_val;
    ram_req.ren   = 1'b0;
    ram_req.raddr = mid_nxt[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        // Writes finish here; a query reads only from the next cycle on, so a
        // write and a probe never meet at the same entry.
        if (accept && in_mode == MODE_WRITE) begin
          ram_req.wen = (32'(in_pos) < DEPTH);
        end
        if (accept && in_mode == MODE_QUERY) begin
          low_nxt   = SRCH_W'(range_low);
          high_nxt  = high_init;
          key_nxt   = in_val;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (low_r <= high_r) begin
          mid_nxt       = sum[SRCH_W:1];
          ram_req.ren   = 1'b1;
          ram_req.raddr = mid_nxt[IDX_W-1:0];
          state_nxt     = S_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        if (elem_below) begin
          low_nxt = mid_r + SRCH_W'(1);
        end else begin
          high_nxt = mid_r - SRCH_W'(1);
        end
        state_nxt = S_PROBE;
      end
      S_DONE: begin
        // Hold the answer until the output register has room.
        if (res_ready) begin
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/binary_search_last_below.sv
// Top level of the last-below binary search: configuration registers, output
// register and the wiring of controller and element store.
// Depends on bsl_pkg, bsl_ram and bsl_ctrl.
//
//   channel | direction | payload                              | accepted when
//   --------+-----------+--------------------------------------+-------------------------
//   in_     | slave     | tuser: mode; tdata: position, value  | in_tvalid && in_tready
//   out_    | master    | tdata: result_index                  | out_tvalid && out_tready
//   cfg_    | write     | index 0 range_low, 1 range_high      | cfg_wen
//
// A query request makes n probes (at most 11 for 1024 entries): each probe
// is one store read and, in the next cycle, one compare, so the read latency
// of the store sets the loop. One request is in work at a time.
// Reset clears the controller state and the output valid; range_low resets to 0 and
// range_high to 1023. The store holds no reset value.
// A waiting result sits in the output register; write requests go on behind
// it, and a query that finishes while it waits holds until it is taken.
module binary_search_last_below
  import bsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,   // [9:0] position, [41:10] item_value, rest zero
  input  logic [0:0]        in_tuser,   // [0] mode
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [10:0] result_index, rest zero
  input  logic              cfg_wen,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  logic [RLO_W-1:0]        range_low_r;
  logic signed [RES_W-1:0] range_high_r;
  logic                    out_valid_r;
  logic [RES_W-1:0]        out_index_r;

  logic             res_ready;
  result_t          res;
  ram_req_t         ram_req;
  logic [VAL_W-1:0] rd_data;

  // Configuration registers; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= RLO_W'(0);
      range_high_r <= RES_W'(DEPTH - 1);
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_RANGE_LOW:  range_low_r  <= cfg_wdata[RLO_W-1:0];
        CFG_RANGE_HIGH: range_high_r <= cfg_wdata[RES_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register: room when empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_index_r <= res.index;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(16 - RES_W)'(0), out_index_r};

  bsl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_mode    (in_tuser[0]),
    .in_pos     (in_tdata[POS_W-1:0]),
    .in_val     (in_tdata[POS_W+VAL_W-1:POS_W]),
    .range_low  (range_low_r),
    .range_high (range_high_r),
    .res_ready  (res_ready),
    .res        (res),
    .ram_req    (ram_req),
    .rd_data    (rd_data)
  );

  bsl_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // A new result never lands on one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (!out_valid_r || out_tready))
    else $error("result loaded over a waiting result");

  // A query blocks the input channel in the cycle after it is accepted.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] == MODE_QUERY) |=> !in_tready)
    else $error("input accepted during a search");

  // The store is never written and read in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.wen && ram_req.ren))
    else $error("store write and probe overlap");

  // A write request produces no result in the next cycle.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] == MODE_WRITE) |=> !res.valid)
    else $error("result produced by a write request");

endmodule

>>> verif/tb_binary_search_last_below.sv
// Testbench for binary_search_last_below: loads the element store through
// write requests, runs search queries and checks each result against its own
// copy of the store and the range registers. Depends on bsl_pkg and the RTL.
module tb_binary_search_last_below;
  import bsl_pkg::*;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam int QUERY_SETTLE = 40;  // outlasts the longest query

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [47:0]       in_tdata = '0;   // [9:0] position, [41:10] item_value
  logic [0:0]        in_tuser = '0;   // [0] mode
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;       // [10:0] result_index
  logic              cfg_wen = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  // Predictor state: element store and range registers as the block sees them.
  logic signed [31:0] model_store [DEPTH];
  logic [RLO_W-1:0]   model_range_low = '0;
  logic [RES_W-1:0]   model_range_high = 11'd1023;

  logic [RES_W-1:0] expected_index_q [$];
  logic [RES_W-1:0] expected_head;
  int error_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic rx_hold = 1'b0;

  binary_search_last_below dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Walk the same probe sequence as the block: last index below the key,
  // else range_low minus one. An empty range makes no probe at all.
  function automatic logic [RES_W-1:0] predict_last_below(logic signed [31:0] key);
    int lo;
    int hi;
    int mid;
    lo = int'(model_range_low);
    hi = int'($signed(model_range_high));
    if (hi > DEPTH - 1) hi = DEPTH - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (model_store[mid] >= key) hi = mid - 1;
      else lo = mid + 1;
    end
    return RES_W'(lo - 1);
  endfunction

  // Offer one request and hold it until accepted. Valid stays high after the
  // handshake so back-to-back requests never see valid dropped and raised in
  // one step; wait_until_idle drops it when traffic stops.
  task automatic send_request(input logic mode, input logic [POS_W-1:0] pos,
                              input logic signed [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {6'd0, val, pos};
    do @(posedge clk); while (!in_tready);
    // Accepted at this edge: update the store copy or queue the answer.
    if (mode == MODE_WRITE) model_store[pos] = val;
    else expected_index_q.push_back(predict_last_below(val));
  endtask

  // Drop valid, wait out every queued answer, then let a trailing write or
  // query finish inside the block before anything touches the registers.
  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_index_q.size() != 0) @(posedge clk);
    repeat (QUERY_SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == CFG_RANGE_LOW) model_range_low = data[RLO_W-1:0];
    else model_range_high = data;
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_range(input logic [CFG_W-1:0] lo_word, input logic [CFG_W-1:0] hi_word);
    wait_until_idle();
    write_config(CFG_RANGE_LOW, lo_word);
    write_config(CFG_RANGE_HIGH, hi_word);
  endtask

  // Load every entry in ascending order, so no query ever probes an entry
  // that was never written. Wide spreads over the full signed range; dense
  // packs small values with long runs of duplicates.
  task automatic fill_store(input bit dense);
    logic signed [31:0] v;
    for (int i = 0; i < DEPTH; i++) begin
      if (dense) v = 32'(i / 40 - 12);
      else v = 32'(longint'(i) * 4194304 - 2147483648 + longint'($urandom_range(4194303)));
      send_request(MODE_WRITE, POS_W'(i), v);
    end
  endtask

  // Keys mostly land on or next to stored elements, where the bound matters.
  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(9);
    case (r)
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return $urandom;
      default: return model_store[$urandom_range(DEPTH - 1)] + 32'(int'($urandom_range(2)) - 1);
    endcase
  endfunction

  // Rewrite one entry with a value between its neighbors, keeping the order; if they are out of order, any value.
  task automatic send_ordered_write();
    int p;
    longint lo_v;
    longint hi_v;
    longint span;
    longint off;
    p = $urandom_range(DEPTH - 1);
    lo_v = (p > 0) ? longint'(model_store[p-1]) : -64'sd2147483648;
    hi_v = (p < DEPTH - 1) ? longint'(model_store[p+1]) : 64'sd2147483647;
    span = hi_v - lo_v + 1;
    if (span <= 0) begin
      send_request(MODE_WRITE, POS_W'(p), $urandom);
    end else begin
      off = longint'({$urandom, $urandom} >> 1) % span;
      send_request(MODE_WRITE, POS_W'(p), 32'(lo_v + off));
    end
  endtask

  // Receiver: check each accepted result against the oldest expectation and
  // pick the ready for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_index_q.size() == 0) begin
        $error("result_index: expected none, got %0d", $signed(out_tdata[RES_W-1:0]));
        error_count++;
      end else begin
        expected_head = expected_index_q.pop_front();
        if (out_tdata[RES_W-1:0] !== expected_head) begin
          $error("result_index: expected %0d, got %0d", $signed(expected_head),
                 $signed(out_tdata[RES_W-1:0]));
          error_count++;
        end
      end
    end
    out_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
  end

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  // Reset range covers the whole store.
  task automatic test_default_range();
    fill_store(1'b0);
    send_request(MODE_QUERY, '0, VAL_MIN);
    send_request(MODE_QUERY, '0, VAL_MAX);
    send_request(MODE_QUERY, '0, model_store[0]);
    send_request(MODE_QUERY, '0, model_store[DEPTH-1]);
    send_request(MODE_QUERY, '0, model_store[511] + 32'sd1);
  endtask

  // Extreme element values at both ends of the store.
  task automatic test_extreme_elements();
    send_request(MODE_WRITE, 10'd0, VAL_MIN);
    send_request(MODE_WRITE, 10'd1023, VAL_MAX);
    send_request(MODE_QUERY, 10'h3FF, VAL_MIN);
    send_request(MODE_QUERY, 10'h155, VAL_MAX);
    send_request(MODE_QUERY, 10'h2AA, VAL_MIN + 32'sd1);
  endtask

  // Single-entry, empty and negative ranges; range_low bit 10 is not stored.
  task automatic test_range_edges();
    set_range(11'd1023, 11'd1023);
    send_request(MODE_QUERY, '0, VAL_MAX);
    send_request(MODE_QUERY, '0, VAL_MIN);
    set_range(11'd5, 11'd4);
    send_request(MODE_QUERY, '0, model_store[300]);
    set_range(11'd0, 11'h7FF);
    send_request(MODE_QUERY, '0, VAL_MAX);
    set_range(11'd1023, 11'h400);
    send_request(MODE_QUERY, '0, VAL_MAX);
    set_range(11'h403, 11'd1023);
    send_request(MODE_QUERY, '0, model_store[600]);
    set_range(11'd0, 11'd0);
    send_request(MODE_QUERY, '0, VAL_MAX);
    send_request(MODE_QUERY, '0, VAL_MIN);
  endtask

  // Break the order and check the same probe walk is followed.
  task automatic test_unsorted_store();
    set_range(11'd0, 11'd1023);
    send_request(MODE_WRITE, 10'd512, VAL_MIN);
    send_request(MODE_WRITE, 10'd100, VAL_MAX);
    send_request(MODE_QUERY, '0, model_store[700]);
    send_request(MODE_QUERY, '0, 32'sd0);
  endtask

  // Hold the receiver off for a long stretch while queries keep coming, so
  // the output register fills and the input stalls.
  task automatic test_backpressure();
    wait_until_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 3) send_ordered_write();
      else send_request(MODE_QUERY, POS_W'($urandom), pick_key());
    end
  endtask

  // Random traffic in four idle/stall phases, each running four blocks under their own range settings.
  task automatic test_random_traffic();
    int send_mix [4] = '{0, 64, 0, 18};
    int stall_mix [4] = '{0, 0, 64, 18};
    int lo;
    int hi;
    int r;
    for (int ph = 0; ph < 4; ph++) begin
      wait_until_idle();
      send_idle_pct = send_mix[ph];
      stall_pct = stall_mix[ph];
      set_range(11'd0, 11'd1023);
      for (int blk = 0; blk < 4; blk++) begin
        r = $urandom_range(5);
        lo = $urandom_range(DEPTH - 1);
        case (r)
          0: begin lo = 0; hi = DEPTH - 1; end
          1: hi = lo - 1 - $urandom_range(3);
          2: hi = lo + $urandom_range(3);
          3: begin lo = $urandom_range(40); hi = DEPTH - 1 - $urandom_range(40); end
          default: hi = $urandom_range(DEPTH - 1);
        endcase
        if (hi > DEPTH - 1) hi = DEPTH - 1;
        if (hi < -1024) hi = -1024;
        set_range(11'(lo) | ($urandom_range(7) == 0 ? 11'h400 : 11'h000), 11'(hi));
        for (int i = 0; i < 27; i++) begin
          r = $urandom_range(99);
          if (r < 70) send_request(MODE_QUERY, POS_W'($urandom), pick_key());
          else if (r < 95) send_ordered_write();
          else send_request(MODE_WRITE, POS_W'($urandom), $urandom);
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) model_store[i] = '0;
    apply_reset();
    test_default_range();
    test_extreme_elements();
    test_range_edges();
    test_unsorted_store();
    test_backpressure();
    test_random_traffic();
    wait_until_idle();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Generous bound on the whole run; a hang ends here.
  initial begin
    #800000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> binary_search_last_below.f
design/bsl_pkg.sv
design/bsl_ram.sv
design/bsl_ctrl.sv
design/binary_search_last_below.sv
verif/tb_binary_search_last_below.sv
